>>> src/u8sv_pkg.sv
package u8sv_pkg;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_LEAD  = 3'd1,
        ERR_OVERLONG  = 3'd2,
        ERR_MISSING   = 3'd3,
        ERR_TRUNCATED = 3'd4
    } err_kind_t;

    // leads whose second byte can make the sequence overlong
    typedef enum logic [2:0] {
        LC_NONE = 3'd0,
        LC_E0   = 3'd1,
        LC_F0   = 3'd2,
        LC_F8   = 3'd3,
        LC_FC   = 3'd4
    } lead_cls_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic       string_valid;
        logic [2:0] error_kind;
    } out_item_t;

    typedef struct packed {
        logic [2:0] pending_followers;
        lead_cls_t  lead_class;
        logic       first_follower_due;
        err_kind_t  first_error;
    } scan_state_t;

    localparam scan_state_t SCAN_STATE_RESET = '{
        pending_followers:  3'd0,
        lead_class:         LC_NONE,
        first_follower_due: 1'b0,
        first_error:        ERR_NONE
    };

    localparam logic [2:0] MAX_FOLLOWERS = 3'd5;

endpackage

>>> src/u8sv_step.sv
module u8sv_step
    import u8sv_pkg::*;
(
    input  scan_state_t state_cur,
    input  in_item_t    item,
    output scan_state_t state_next,
    output out_item_t   verdict
);

    logic [7:0]  b;
    logic        overlong_2nd;
    scan_state_t upd;
    err_kind_t   final_err;

    assign b = item.byte_value;

    always_comb begin
        unique case (state_cur.lead_class)
            LC_E0:   overlong_2nd = (b & 8'hE0) == 8'h80;
            LC_F0:   overlong_2nd = (b & 8'hF0) == 8'h80;
            LC_F8:   overlong_2nd = (b & 8'hF8) == 8'h80;
            LC_FC:   overlong_2nd = (b & 8'hFC) == 8'h80;
            default: overlong_2nd = 1'b0;
        endcase
    end

    always_comb begin
        upd = state_cur;
        if (state_cur.first_error == ERR_NONE) begin
            if (state_cur.pending_followers != 3'd0) begin
                if (state_cur.first_follower_due && overlong_2nd) begin
                    upd.first_error = ERR_OVERLONG;
                end else if (b[7:6] != 2'b10) begin
                    upd.first_error = ERR_MISSING;
                end else begin
                    upd.pending_followers  = state_cur.pending_followers - 3'd1;
                    upd.first_follower_due = 1'b0;
                    if (state_cur.pending_followers == 3'd1) begin
                        upd.lead_class = LC_NONE;
                    end
                end
            end else if (b[7] == 1'b0) begin
                // plain ASCII: nothing to track
            end else if ((b & 8'hE0) == 8'hC0) begin
                if ((b & 8'hFE) == 8'hC0) begin
                    upd.first_error = ERR_OVERLONG;
                end else begin
                    upd.pending_followers  = 3'd1;
                    upd.lead_class         = LC_NONE;
                    upd.first_follower_due = 1'b1;
                end
            end else if ((b & 8'hF0) == 8'hE0) begin
                upd.pending_followers  = 3'd2;
                upd.lead_class         = (b == 8'hE0) ? LC_E0 : LC_NONE;
                upd.first_follower_due = 1'b1;
            end else if ((b & 8'hF8) == 8'hF0) begin
                upd.pending_followers  = 3'd3;
                upd.lead_class         = (b == 8'hF0) ? LC_F0 : LC_NONE;
                upd.first_follower_due = 1'b1;
            end else if ((b & 8'hFC) == 8'hF8) begin
                upd.pending_followers  = 3'd4;
                upd.lead_class         = (b == 8'hF8) ? LC_F8 : LC_NONE;
                upd.first_follower_due = 1'b1;
            end else if ((b & 8'hFE) == 8'hFC) begin
                upd.pending_followers  = MAX_FOLLOWERS;
                upd.lead_class         = (b == 8'hFC) ? LC_FC : LC_NONE;
                upd.first_follower_due = 1'b1;
            end else begin
                // stray continuation byte, FE or FF
                upd.first_error = ERR_BAD_LEAD;
            end
        end
    end

    always_comb begin
        final_err = upd.first_error;
        if (upd.first_error == ERR_NONE && upd.pending_followers != 3'd0) begin
            final_err = ERR_TRUNCATED;
        end
        verdict.string_valid = (final_err == ERR_NONE);
        verdict.error_kind   = final_err;
        // the verdict closes the string, so the scan restarts clean
        state_next = item.last_byte ? SCAN_STATE_RESET : upd;
    end

endmodule

>>> src/u8sv_out_stage.sv
module u8sv_out_stage
    import u8sv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  out_item_t load_data,
    output logic      can_load,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      m_valid_reg;
    logic      m_valid_next;
    out_item_t m_data_reg;

    assign can_load = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= load_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> src/utf8_stream_validator_unit.sv
// Streaming UTF-8 (six-byte forms) checker, one byte per request.
// Throughput: one byte per cycle while s_ready is high; the scan state updates on the accepting edge.
// The verdict of a final byte is registered and shows on m_valid in the cycle after the byte is accepted.
// Input stalls only while a verdict waits in the output register and m_ready is low.
// Reset (aresetn low, synchronous) clears the scan state and drops m_valid.
module utf8_stream_validator_unit
    import u8sv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    scan_state_t state_reg;
    scan_state_t state_next;
    out_item_t   verdict;
    logic        can_load;
    logic        accept;

    assign s_ready = can_load;
    assign accept  = s_valid && s_ready;

    u8sv_step u_step (
        .state_cur  (state_reg),
        .item       (s_data),
        .state_next (state_next),
        .verdict    (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_STATE_RESET;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    u8sv_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept && s_data.last_byte),
        .load_data (verdict),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_verdict_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.string_valid == (m_data.error_kind == ERR_NONE)))
        else $error("verdict flag disagrees with error kind");

    a_pending_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pending_followers <= MAX_FOLLOWERS)
        else $error("follower count out of range");

    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.last_byte) |=>
            (state_reg.pending_followers == 3'd0 && state_reg.first_error == ERR_NONE))
        else $error("scan state not cleared after final byte");

    a_no_verdict_midstring: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_data.last_byte) |=> !$rose(m_valid))
        else $error("verdict raised without a final byte");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_data.last_byte && state_reg.first_error != ERR_NONE) |=>
            $stable(state_reg.first_error))
        else $error("held error changed mid-string");

endmodule

>>> sim/utf8_verdict_checker.sv
`timescale 1ns / 100ps

module utf8_verdict_checker
    import u8sv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        mismatches,
    output int        verdicts_checked,
    output int        verdicts_due
);

    logic [2:0] followers_left;
    lead_cls_t  open_lead;
    logic       at_first_follower;
    err_kind_t  held_error;
    out_item_t  due_verdicts[$];

    function automatic logic second_too_small(lead_cls_t cls, logic [7:0] b);
        case (cls)
            LC_E0:   return b[7:5] == 3'b100;
            LC_F0:   return b[7:4] == 4'b1000;
            LC_F8:   return b[7:3] == 5'b10000;
            LC_FC:   return b[7:2] == 6'b100000;
            default: return 1'b0;
        endcase
    endfunction

    task automatic clear_scan();
        followers_left    = '0;
        open_lead         = LC_NONE;
        at_first_follower = 1'b0;
        held_error        = ERR_NONE;
    endtask

    // Advance the scan by one accepted byte; queue a verdict on the final byte.
    task automatic scan_byte(in_item_t req);
        logic [7:0] b;
        out_item_t  verdict;
        b = req.byte_value;
        if (held_error == ERR_NONE) begin
            if (followers_left != 0) begin
                if (at_first_follower && second_too_small(open_lead, b)) begin
                    held_error = ERR_OVERLONG;
                end else if (b[7:6] != 2'b10) begin
                    held_error = ERR_MISSING;
                end else begin
                    followers_left    = followers_left - 3'd1;
                    at_first_follower = 1'b0;
                    if (followers_left == 0) begin
                        open_lead = LC_NONE;
                    end
                end
            end else begin
                // order matters: C0/C1 must match before the general two-byte lead
                casez (b)
                    8'b0???????: ;
                    8'b1100000?: held_error = ERR_OVERLONG;
                    8'b110?????: begin
                        followers_left = 3'd1;
                        open_lead      = LC_NONE;
                    end
                    8'b1110????: begin
                        followers_left = 3'd2;
                        open_lead      = (b == 8'hE0) ? LC_E0 : LC_NONE;
                    end
                    8'b11110???: begin
                        followers_left = 3'd3;
                        open_lead      = (b == 8'hF0) ? LC_F0 : LC_NONE;
                    end
                    8'b111110??: begin
                        followers_left = 3'd4;
                        open_lead      = (b == 8'hF8) ? LC_F8 : LC_NONE;
                    end
                    8'b1111110?: begin
                        followers_left = MAX_FOLLOWERS;
                        open_lead      = (b == 8'hFC) ? LC_FC : LC_NONE;
                    end
                    default: held_error = ERR_BAD_LEAD;
                endcase
                if (followers_left != 0) begin
                    at_first_follower = 1'b1;
                end
            end
        end
        if (req.last_byte) begin
            if (held_error == ERR_NONE && followers_left != 0) begin
                held_error = ERR_TRUNCATED;
            end
            verdict.string_valid = (held_error == ERR_NONE);
            verdict.error_kind   = held_error;
            due_verdicts.push_back(verdict);
            clear_scan();
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            clear_scan();
            due_verdicts.delete();
        end else begin
            // a verdict leaves only after its final byte has been accepted, so pop first
            if (m_valid && m_ready) begin
                if (due_verdicts.size() == 0) begin
                    $error("verdict %0h arrived with no string outstanding", m_data);
                    mismatches++;
                end else begin
                    want = due_verdicts.pop_front();
                    verdicts_checked++;
                    if (m_data.string_valid !== want.string_valid) begin
                        $error("string_valid: expected %0b, got %0b",
                               want.string_valid, m_data.string_valid);
                        mismatches++;
                    end
                    if (m_data.error_kind !== want.error_kind) begin
                        $error("error_kind: expected %0d, got %0d",
                               want.error_kind, m_data.error_kind);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                scan_byte(s_data);
            end
        end
        verdicts_due = due_verdicts.size();
    end

endmodule

>>> sim/tb_utf8_stream_validator_unit.sv
`timescale 1ns / 100ps

module tb_utf8_stream_validator_unit;
    import u8sv_pkg::*;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int mismatches;
    int verdicts_checked;
    int verdicts_due;
    int bytes_sent   = 0;
    int strings_sent = 0;
    bit calm         = 1'b0;

    utf8_stream_validator_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    utf8_verdict_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .mismatches       (mismatches),
        .verdicts_checked (verdicts_checked),
        .verdicts_due     (verdicts_due)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 38);
    end

    task automatic put_byte(logic [7:0] value, logic last);
        while (!calm && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_data.byte_value <= value;
        s_data.last_byte  <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (last) begin
            strings_sent++;
        end
    endtask

    task automatic drain_verdicts();
        s_valid <= 1'b0;
        do @(posedge aclk); while (verdicts_due != 0);
    endtask

    // Mostly well-formed sequences with random payload; some noise and broken ones.
    task automatic random_string();
        logic [7:0] seq[$];
        logic [7:0] lead;
        logic [7:0] mask;
        logic [7:0] follower;
        int         units;
        int         kind;
        int         n;
        int         brk;
        units = $urandom_range(1, 5);
        for (int u = 0; u < units; u++) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                seq.push_back(8'($urandom_range(127)));
            end else if (kind < 85) begin
                n    = $urandom_range(1, 5);
                mask = 8'hFF >> (n + 2);
                lead = 8'hFE << (6 - n);
                if ($urandom_range(3) != 0) begin
                    lead = lead | (8'($urandom) & mask);
                end
                seq.push_back(lead);
                for (int k = 1; k <= n; k++) begin
                    follower = 8'h80 | (8'($urandom) & 8'h3F);
                    if (k == 1 && $urandom_range(3) == 0) begin
                        follower = 8'h80;
                    end
                    seq.push_back(follower);
                end
                brk = $urandom_range(9);
                if (brk == 0) begin
                    repeat ($urandom_range(1, n)) void'(seq.pop_back());
                end else if (brk == 1) begin
                    seq[seq.size() - 1 - $urandom_range(n - 1)] = 8'($urandom);
                end
            end else begin
                seq.push_back(8'($urandom));
            end
        end
        foreach (seq[i]) begin
            put_byte(seq[i], i == seq.size() - 1);
        end
    endtask

    initial begin
        logic [8:0] directed [0:24];
        int         n_directed;
        bit         paused;
        directed = '{
            {8'hFE, 1'b1},                                  // FE as lead
            {8'h00, 1'b0}, {8'hC1, 1'b1},                   // zero byte, then C1
            {8'hE0, 1'b0}, {8'h9F, 1'b1},                   // overlong three-byte
            {8'hF0, 1'b0}, {8'h8F, 1'b1},
            {8'hF8, 1'b0}, {8'h87, 1'b1},
            {8'hFC, 1'b0}, {8'h83, 1'b1},
            {8'hFC, 1'b0}, {8'h84, 1'b0}, {8'h80, 1'b0},   // legal six-byte, smallest second byte
            {8'h80, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b1},
            {8'hC2, 1'b0}, {8'h41, 1'b1},                   // follower missing
            {8'hE1, 1'b0}, {8'h80, 1'b1},                   // cut short by the end
            {8'h80, 1'b0}, {8'hC0, 1'b0}, {8'hFF, 1'b1},   // first error wins
            {8'hFF, 1'b1}
        };
        paused = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            put_byte(directed[i][8:1], directed[i][0]);
        end
        n_directed = bytes_sent;
        drain_verdicts();

        while (bytes_sent < n_directed + 1150) begin
            calm = (bytes_sent >= 300 && bytes_sent < 520);
            if (!paused && bytes_sent >= 700) begin
                drain_verdicts();
                paused = 1'b1;
            end
            random_string();
        end
        drain_verdicts();
        repeat (8) @(posedge aclk);

        $display("Sent %0d strings in %0d bytes (%0d directed), %0d verdicts compared",
                 strings_sent, bytes_sent, n_directed, verdicts_checked);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Run timed out with %0d verdicts outstanding", verdicts_due);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
src/u8sv_pkg.sv
src/u8sv_step.sv
src/u8sv_out_stage.sv
src/utf8_stream_validator_unit.sv
sim/utf8_verdict_checker.sv
sim/tb_utf8_stream_validator_unit.sv
